### rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit allocator package
// Shared types, constants and codes of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

	localparam int ARENA_BYTES  = 65536;
	localparam int HEADER_BYTES = 17;
	localparam int SPLIT_SLACK  = 10;

	// Arena offset width and the width of the shared adder, which must hold
	// a 16-bit request plus an offset plus a header without wrapping.
	localparam int AW = $clog2(ARENA_BYTES);
	localparam int SW = ((AW > 16) ? AW : 16) + 2;

	typedef logic [AW-1:0] addr_t;
	typedef logic [SW-1:0] sum_t;

	// Request mode codes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Block header used marks.
	localparam logic TYPE_FREE = 1'b0;
	localparam logic TYPE_USED = 1'b1;

	// Response status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_BAD_FREE = 2'd2;

	localparam sum_t HDR_W   = SW'(HEADER_BYTES);
	localparam sum_t SLACK_W = SW'(SPLIT_SLACK);
	localparam sum_t ARENA_W = SW'(ARENA_BYTES);
	// Adding ~req plus this bias gives size - req - HEADER_BYTES modulo 2^SW.
	localparam sum_t REM_BIAS = SW'(1 - HEADER_BYTES);

	typedef struct packed {
		logic        mode;
		logic [15:0] request_bytes;
		logic [15:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_address;
	} rsp_t;

	typedef struct packed {
		logic  used;
		addr_t size;
	} hdr_t;

	localparam hdr_t HDR_RESET = '{used: TYPE_FREE, size: AW'(ARENA_BYTES - HEADER_BYTES)};

	typedef struct packed {
		logic  we;
		addr_t waddr;
		hdr_t  wdata;
		logic  re;
		addr_t raddr;
	} ram_ctl_t;

	typedef enum logic [1:0] {
		CMP_L_R   = 2'd0,
		CMP_SUM_R = 2'd1,
		CMP_L_SUM = 2'd2
	} cmp_sel_t;

	typedef struct packed {
		sum_t     a;
		sum_t     b;
		sum_t     c;
		sum_t     l;
		sum_t     r;
		cmp_sel_t sel;
	} alu_op_t;

	typedef struct packed {
		sum_t sum;
		logic ge;
		logic eq;
	} alu_res_t;

endpackage

### rtl/ffa_hdr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header store
// One header per arena offset, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ffa_hdr_ram (
	input  logic             clk,
	input  logic             arst_n,
	input  ffa_pkg::ram_ctl_t ctl,
	output ffa_pkg::hdr_t    rdata
);
	import ffa_pkg::*;

	hdr_t mem [ARENA_BYTES];
	hdr_t rdata_q;
	logic zero_written_q;
	logic rd_zero_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[ctl.raddr];
		end
	end

	// Only offset zero has a defined value after reset: until it is first
	// written, reads of it return the whole-arena free block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_written_q <= 1'b0;
			rd_zero_q      <= 1'b0;
		end else begin
			if (ctl.we && (ctl.waddr == '0)) begin
				zero_written_q <= 1'b1;
			end
			if (ctl.re) begin
				rd_zero_q <= (ctl.raddr == '0) && !zero_written_q;
			end
		end
	end

	assign rdata = rd_zero_q ? HDR_RESET : rdata_q;

endmodule

### rtl/ffa_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared arithmetic unit
// Three-input adder with one magnitude and equality compare.
// ---------------------------------------------------------------------------
module ffa_alu (
	input  ffa_pkg::alu_op_t  op,
	output ffa_pkg::alu_res_t res
);
	import ffa_pkg::*;

	sum_t sum;
	sum_t lhs;
	sum_t rhs;

	assign sum = op.a + op.b + op.c;

	always_comb begin
		lhs = op.l;
		rhs = op.r;
		unique case (op.sel)
			CMP_L_R: begin
				lhs = op.l;
				rhs = op.r;
			end
			CMP_SUM_R: begin
				lhs = sum;
				rhs = op.r;
			end
			CMP_L_SUM: begin
				lhs = op.l;
				rhs = sum;
			end
			default: begin
				lhs = op.l;
				rhs = op.r;
			end
		endcase
	end

	assign res.sum = sum;
	assign res.ge  = (lhs >= rhs);
	assign res.eq  = (lhs == rhs);

endmodule

### rtl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit heap allocator
// Allocates and frees blocks of a byte arena kept as an address-ordered
// chain of headers, with first-fit search, splitting and forward merging.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------
//  req       req_valid / req_stall  mode, request_bytes, free_address (req_t)
//  rsp       rsp_valid / rsp_stall  status, granted_address (rsp_t)
//
// One request is in work at a time; req_stall is high from the transfer of a
// request until its result has been moved into the response register.
// An allocate visits each block of the walk in S_AWALK and S_ADATA, then
// marks, splits and forms the address in S_ASPL to S_AOK, or ends in S_AWALK
// past the last block when nothing fits. A free walks each block up to and
// including the target in S_FWALK and S_FDATA, merges each free neighbor in
// S_MCHK, S_MDATA and S_MADV, and finishes from S_MCHK or S_MDATA. A free
// address inside the first header is refused at once. Every request then
// loads its result from S_DONE once the response register can take it.
// The walk is bound by the header store: every visited header is one
// registered read feeding one shared add/compare, one access per cycle.
// Reset needs no clearing pass: only offset zero holds a defined header.
// A result that waits in the response register does not block the next
// request transfer.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ffa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ffa_pkg::rsp_t rsp
);
	import ffa_pkg::*;

	// Sequencer states. The A states walk and allocate, F states walk to a
	// freed block and M states merge its free successors into it.
	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_AWALK = 13'b0000000000010,
		S_ADATA = 13'b0000000000100,
		S_ASPL  = 13'b0000000001000,
		S_ANB   = 13'b0000000010000,
		S_AREM  = 13'b0000000100000,
		S_AOK   = 13'b0000001000000,
		S_FWALK = 13'b0000010000000,
		S_FDATA = 13'b0000100000000,
		S_MCHK  = 13'b0001000000000,
		S_MDATA = 13'b0010000000000,
		S_MADV  = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t   state_q, state_d;
	sum_t     off_q, off_d;
	sum_t     nb_q, nb_d;
	addr_t    tgt_q, tgt_d;
	addr_t    size_q, size_d;
	logic     found_q, found_d;
	logic [15:0] req_bytes_q, req_bytes_d;
	logic [15:0] addr_q, addr_d;
	rsp_t     res_q, res_d;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	ram_ctl_t ram_ctl;
	hdr_t     rd;
	alu_op_t  op;
	alu_res_t alu;
	logic     off_end;
	logic     rsp_load;

	ffa_hdr_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ram_ctl),
		.rdata  (rd)
	);

	ffa_alu u_alu (
		.op  (op),
		.res (alu)
	);

	// The walk has run past the last block.
	assign off_end = (off_q >= ARENA_W);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d     = state_q;
		off_d       = off_q;
		nb_d        = nb_q;
		tgt_d       = tgt_q;
		size_d      = size_q;
		found_d     = found_q;
		req_bytes_d = req_bytes_q;
		addr_d      = addr_q;
		res_d       = res_q;
		op          = '{a: '0, b: '0, c: '0, l: '0, r: '0, sel: CMP_L_R};
		ram_ctl     = '0;

		unique case (state_q)
			S_IDLE: begin
				// Screen free addresses that lie inside the first header.
				op.l = SW'(req.free_address);
				op.r = HDR_W;
				if (req_valid) begin
					req_bytes_d = req.request_bytes;
					addr_d      = req.free_address;
					off_d       = '0;
					if (req.mode == MODE_ALLOC) begin
						state_d = S_AWALK;
					end else if (!alu.ge) begin
						res_d   = '{status: STAT_BAD_FREE, granted_address: '0};
						state_d = S_DONE;
					end else begin
						state_d = S_FWALK;
					end
				end
			end

			S_AWALK: begin
				if (off_end) begin
					res_d   = '{status: STAT_NO_SPACE, granted_address: '0};
					state_d = S_DONE;
				end else begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = off_q[AW-1:0];
					state_d       = S_ADATA;
				end
			end

			S_ADATA: begin
				// Fit test on the header, and the next block offset in case
				// this one does not fit.
				op.a = off_q;
				op.b = HDR_W;
				op.c = SW'(rd.size);
				op.l = SW'(rd.size);
				op.r = SW'(req_bytes_q);
				if ((rd.used == TYPE_FREE) && alu.ge) begin
					size_d  = rd.size;
					state_d = S_ASPL;
				end else begin
					off_d   = alu.sum;
					state_d = S_AWALK;
				end
			end

			S_ASPL: begin
				// Split only if the block holds the request, a new header and
				// the slack.
				op.a   = SW'(req_bytes_q);
				op.b   = HDR_W;
				op.c   = SLACK_W;
				op.l   = SW'(size_q);
				op.sel = CMP_L_SUM;
				if (alu.ge) begin
					state_d = S_ANB;
				end else begin
					ram_ctl.we    = 1'b1;
					ram_ctl.waddr = off_q[AW-1:0];
					ram_ctl.wdata = '{used: TYPE_USED, size: size_q};
					state_d       = S_AOK;
				end
			end

			S_ANB: begin
				op.a   = off_q;
				op.b   = HDR_W;
				op.c   = SW'(req_bytes_q);
				op.r   = ARENA_W;
				op.sel = CMP_SUM_R;
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = off_q[AW-1:0];
				if (alu.ge) begin
					// The split header would fall outside the arena.
					ram_ctl.wdata = '{used: TYPE_USED, size: size_q};
					state_d       = S_AOK;
				end else begin
					ram_ctl.wdata = '{used: TYPE_USED, size: AW'(req_bytes_q)};
					nb_d          = alu.sum;
					state_d       = S_AREM;
				end
			end

			S_AREM: begin
				// Remainder size is size - request - header, formed by adding
				// the complement of the request.
				op.a          = SW'(size_q);
				op.b          = ~SW'(req_bytes_q);
				op.c          = REM_BIAS;
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = nb_q[AW-1:0];
				ram_ctl.wdata = '{used: TYPE_FREE, size: alu.sum[AW-1:0]};
				state_d       = S_AOK;
			end

			S_AOK: begin
				op.a    = off_q;
				op.b    = HDR_W;
				res_d   = '{status: STAT_OK, granted_address: alu.sum[15:0]};
				state_d = S_DONE;
			end

			S_FWALK: begin
				// The data address of this block against the address freed.
				op.a   = off_q;
				op.b   = HDR_W;
				op.r   = SW'(addr_q);
				op.sel = CMP_SUM_R;
				if (off_end || (alu.ge && !alu.eq)) begin
					res_d   = '{status: STAT_BAD_FREE, granted_address: '0};
					state_d = S_DONE;
				end else begin
					found_d       = alu.eq;
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = off_q[AW-1:0];
					state_d       = S_FDATA;
				end
			end

			S_FDATA: begin
				op.a = off_q;
				op.b = HDR_W;
				op.c = SW'(rd.size);
				if (found_q) begin
					tgt_d   = off_q[AW-1:0];
					size_d  = rd.size;
					nb_d    = alu.sum;
					state_d = S_MCHK;
				end else begin
					off_d   = alu.sum;
					state_d = S_FWALK;
				end
			end

			S_MCHK: begin
				op.a   = nb_q;
				op.r   = ARENA_W;
				op.sel = CMP_SUM_R;
				if (alu.ge) begin
					ram_ctl.we    = 1'b1;
					ram_ctl.waddr = tgt_q;
					ram_ctl.wdata = '{used: TYPE_FREE, size: size_q};
					res_d         = '{status: STAT_OK, granted_address: '0};
					state_d       = S_DONE;
				end else begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = nb_q[AW-1:0];
					state_d       = S_MDATA;
				end
			end

			S_MDATA: begin
				op.a = SW'(size_q);
				op.b = HDR_W;
				op.c = SW'(rd.size);
				if (rd.used != TYPE_FREE) begin
					ram_ctl.we    = 1'b1;
					ram_ctl.waddr = tgt_q;
					ram_ctl.wdata = '{used: TYPE_FREE, size: size_q};
					res_d         = '{status: STAT_OK, granted_address: '0};
					state_d       = S_DONE;
				end else begin
					size_d  = alu.sum[AW-1:0];
					state_d = S_MADV;
				end
			end

			S_MADV: begin
				// The read data still holds the absorbed header.
				op.a    = nb_q;
				op.b    = HDR_W;
				op.c    = SW'(rd.size);
				nb_d    = alu.sum;
				state_d = S_MCHK;
			end

			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		off_q       <= off_d;
		nb_q        <= nb_d;
		tgt_q       <= tgt_d;
		size_q      <= size_d;
		found_q     <= found_d;
		req_bytes_q <= req_bytes_d;
		addr_q      <= addr_d;
		res_q       <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
